// ===== rtl/mbct_pkg.sv =====
// ----------------------------------------------------------------------------
// mbct_pkg
// Shared types and constants for the multibyte character boundary tracker.
// ----------------------------------------------------------------------------
package mbct_pkg;

   // Encoding codes held in the encoding mode register.
   localparam logic [3:0] ENC_SINGLE  = 4'd0;
   localparam logic [3:0] ENC_UTF8    = 4'd1;
   localparam logic [3:0] ENC_SJIS    = 4'd2;
   localparam logic [3:0] ENC_BIG5    = 4'd3;
   localparam logic [3:0] ENC_GBK     = 4'd4;
   localparam logic [3:0] ENC_UHC     = 4'd5;
   localparam logic [3:0] ENC_EUCJP   = 4'd6;
   localparam logic [3:0] ENC_EUCCN   = 4'd7;
   localparam logic [3:0] ENC_EUCTW   = 4'd8;
   localparam logic [3:0] ENC_GB18030 = 4'd9;

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENCODING_MODE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SEARCH_BYTE   = 1'd1;

   localparam int unsigned OUT_COUNT_BITS = 16;

   // Decoded outcome of one byte.
   typedef struct packed {
      logic [2:0] state;
      logic       complete;
      logic       match;
   } mbct_result_type;

endpackage

// ===== rtl/mbct_next.sv =====
// ----------------------------------------------------------------------------
// mbct_next
// Next-state logic: one byte against the current sequence state and encoding.
// ----------------------------------------------------------------------------
module mbct_next
   import mbct_pkg::*;
(
   input  logic [2:0]      cur_state,
   input  logic [7:0]      data_byte,
   input  logic [3:0]      encoding_mode,
   input  logic [7:0]      search_byte,
   output mbct_result_type result
);

   logic [2:0] st;
   logic [2:0] nxt;
   logic       is_digit;

   always_comb begin
      // A zero byte always restarts from the single-byte state.
      st = (data_byte == 8'h00) ? 3'd0 : cur_state;
      is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
      nxt = 3'd0;
      case (encoding_mode)
         ENC_UTF8: begin
            if (st < 3'd2 && data_byte >= 8'h80) begin
               // Stray continuation bytes leave the state where it was.
               if (data_byte >= 8'hfc)      nxt = 3'd6;
               else if (data_byte >= 8'hf8) nxt = 3'd5;
               else if (data_byte >= 8'hf0) nxt = 3'd4;
               else if (data_byte >= 8'he0) nxt = 3'd3;
               else if (data_byte >= 8'hc0) nxt = 3'd2;
               else                         nxt = st;
            end else if (st > 3'd2 && data_byte > 8'h7f) begin
               nxt = st - 3'd1;
            end else begin
               nxt = 3'd0;
            end
         end
         ENC_SJIS: begin
            if (st < 3'd2 && data_byte > 8'h80 &&
                !(data_byte > 8'h9f && data_byte < 8'he0)) nxt = 3'd2;
            else if (st == 3'd2)                           nxt = 3'd1;
            else                                           nxt = 3'd0;
         end
         ENC_BIG5, ENC_EUCCN: begin
            if (st < 3'd2 && data_byte > 8'ha0) nxt = 3'd2;
            else if (st == 3'd2)                nxt = 3'd1;
            else                                nxt = 3'd0;
         end
         ENC_GBK, ENC_UHC: begin
            if (st < 3'd2 && data_byte > 8'h7f) nxt = 3'd2;
            else if (st == 3'd2)                nxt = 3'd1;
            else                                nxt = 3'd0;
         end
         ENC_EUCJP: begin
            if (st < 3'd3 && data_byte == 8'h8f) nxt = 3'd3;
            else if (st != 3'd2 && (data_byte == 8'h8e || data_byte > 8'ha0))
               nxt = 3'd2;
            else if (st == 3'd2)                 nxt = 3'd1;
            else                                 nxt = 3'd0;
         end
         ENC_EUCTW: begin
            if (st < 3'd4 && data_byte == 8'h8e)                    nxt = 3'd4;
            else if (st == 3'd4 && data_byte > 8'ha0)               nxt = 3'd3;
            else if ((st == 3'd3 || st < 3'd2) && data_byte > 8'ha0) nxt = 3'd2;
            else if (st == 3'd2)                                    nxt = 3'd1;
            else                                                    nxt = 3'd0;
         end
         ENC_GB18030: begin
            if (st < 3'd2 && data_byte > 8'h80) nxt = 3'd2;
            else if (st == 3'd2)                nxt = is_digit ? 3'd3 : 3'd1;
            else if (st == 3'd3)                nxt = is_digit ? 3'd1 : 3'd3;
            else                                nxt = 3'd0;
         end
         default: begin
            nxt = 3'd0;
         end
      endcase
   end

   assign result.state    = nxt;
   assign result.complete = (nxt < 3'd2);
   assign result.match    = (nxt == 3'd0) && (data_byte == search_byte);

endmodule

// ===== rtl/multibyte_char_boundary_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// multibyte_char_boundary_tracker_unit
// Follows character boundaries in a byte stream under a selected encoding.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the req_ channel (valid/ready) and every byte yields one
//   word on the rsp_ channel: the new sequence state, a character-complete
//   flag, a search-byte match flag and the running character count.
//   The csr_ port selects the encoding and the search byte; write it only
//   while no byte is in flight.
//   A byte waits in the input register and then moves into the result
//   register, with the state update between, once the result register is
//   free; rsp_valid rises when it moves.
//   Throughput is one byte per cycle while the receiver takes the words; the
//   state and count registers close their loop through the next-state logic.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more byte, after which req_ready drops.
//   Reset empties both registers, clears the state and the count, and sets
//   the encoding to single-byte with a search byte of zero.
//   A zero byte clears the state and the count.
// ----------------------------------------------------------------------------
module multibyte_char_boundary_tracker_unit
   import mbct_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_char_state,
   output logic                      rsp_char_complete,
   output logic                      rsp_byte_match,
   output logic [OUT_COUNT_BITS-1:0] rsp_char_count,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [7:0]                csr_wdata
);

   localparam int unsigned ExtBits =
      (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic [2:0]                seq_state_ff;
   logic [COUNT_BITS-1:0]     count_ff;
   logic [COUNT_BITS-1:0]     count_in;
   logic [3:0]                mode_ff;
   logic [7:0]                search_ff;
   logic                      rsp_valid_ff;
   mbct_result_type           rsp_result_ff;
   logic [OUT_COUNT_BITS-1:0] rsp_count_ff;
   logic [ExtBits-1:0]        count_ext;
   mbct_result_type           nxt;
   logic                      advance;

   mbct_next u_next (
      .cur_state     (seq_state_ff),
      .data_byte     (in_byte_ff),
      .encoding_mode (mode_ff),
      .search_byte   (search_ff),
      .result        (nxt)
   );

   // The input register moves on whenever the result register is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (in_byte_ff == 8'h00)
         count_in = '0;
      else if (nxt.complete && !(&count_ff))
         count_in = count_ff + COUNT_BITS'(1);
      else
         count_in = count_ff;
   end

   assign count_ext = ExtBits'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ENC_SINGLE;
         search_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ENCODING_MODE: mode_ff   <= csr_wdata[3:0];
            REG_SEARCH_BYTE:   search_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         seq_state_ff <= nxt.state;
         count_ff     <= count_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= nxt;
         rsp_count_ff  <= count_ext[OUT_COUNT_BITS-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_state    = rsp_result_ff.state;
   assign rsp_char_complete = rsp_result_ff.complete;
   assign rsp_byte_match    = rsp_result_ff.match;
   assign rsp_char_count    = rsp_count_ff;

endmodule

// ===== rtl/mbct_checker.sv =====
// ----------------------------------------------------------------------------
// mbct_checker
// Port-level checks for the multibyte character boundary tracker.
// ----------------------------------------------------------------------------
module mbct_checker
   import mbct_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [2:0]                rsp_char_state,
   input logic                      rsp_char_complete,
   input logic                      rsp_byte_match,
   input logic [OUT_COUNT_BITS-1:0] rsp_char_count
);

   // A stalled result word stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_state) &&
         $stable(rsp_char_count) && $stable(rsp_byte_match))
      else $error("result word changed while stalled");

   a_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_char_complete == (rsp_char_state < 3'd2))
      else $error("complete flag disagrees with state");

   a_match_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_match |-> rsp_char_state == 3'd0)
      else $error("match flagged inside a multibyte sequence");

   a_state_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_char_state <= 3'd6)
      else $error("state out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind multibyte_char_boundary_tracker_unit mbct_checker u_mbct_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_char_state    (rsp_char_state),
   .rsp_char_complete (rsp_char_complete),
   .rsp_byte_match    (rsp_byte_match),
   .rsp_char_count    (rsp_char_count)
);

// ===== test/multibyte_char_boundary_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// multibyte_char_boundary_tracker_unit_tb
// Self-checking bench for the multibyte character boundary tracker. Bytes are
// streamed through the req_ channel under every encoding and two spare codes,
// and each rsp_ word is compared with a cycle-free predictor of the sequence
// state, the completion and match flags and the saturating character count.
// ----------------------------------------------------------------------------
module multibyte_char_boundary_tracker_unit_tb;
   import mbct_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CHAR_COUNT_BITS = 16;
   localparam int unsigned CYCLE_LIMIT     = 600000;
   localparam int unsigned PHASE_BYTES     = 32;
   localparam int unsigned RSP_STALL_LEN   = 150;
   localparam int unsigned DRAIN_CYCLES    = 4;

   // Encoding codes with no encoding behind them.
   localparam logic [3:0] ENC_SPARE_LO = 4'd12;
   localparam logic [3:0] ENC_SPARE_HI = 4'd15;

   typedef struct packed {
      mbct_result_type           flags;
      logic [OUT_COUNT_BITS-1:0] count;
   } tracked_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_data_byte = 8'h00;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [2:0]                rsp_char_state;
   logic                      rsp_char_complete;
   logic                      rsp_byte_match;
   logic [OUT_COUNT_BITS-1:0] rsp_char_count;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_ENCODING_MODE;
   logic [7:0]                csr_wdata = 8'h00;

   // Register copies and tracker state as the predictor sees them.
   logic [3:0]                 mode_cfg = ENC_SINGLE;
   logic [7:0]                 search_cfg = 8'h00;
   logic [2:0]                 seq_now = 3'd0;
   logic [CHAR_COUNT_BITS-1:0] chars_seen = '0;

   logic [7:0]       byte_backlog[$];
   tracked_word_type expected_words[$];

   logic        req_taken = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned stall_requests = 0;
   int unsigned stalls_served = 0;
   int unsigned stall_left = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;

   multibyte_char_boundary_tracker_unit #(
      .COUNT_BITS(CHAR_COUNT_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_char_state    (rsp_char_state),
      .rsp_char_complete (rsp_char_complete),
      .rsp_byte_match    (rsp_byte_match),
      .rsp_char_count    (rsp_char_count),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multibyte_char_boundary_tracker_unit_tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic logic [2:0] advance_seq(input logic [2:0] st, input logic [7:0] c,
                                              input logic [3:0] mode);
      logic [2:0] s;
      logic       digit;
      s = (c == 8'h00) ? 3'd0 : st;
      digit = (c >= 8'h30) && (c <= 8'h39);
      case (mode)
         ENC_UTF8: begin
            if (s < 3'd2 && c >= 8'h80) begin
               // A continuation byte here is a stray and leaves the state alone.
               if (c >= 8'hfc) s = 3'd6;
               else if (c >= 8'hf8) s = 3'd5;
               else if (c >= 8'hf0) s = 3'd4;
               else if (c >= 8'he0) s = 3'd3;
               else if (c >= 8'hc0) s = 3'd2;
            end else if (s > 3'd2 && c > 8'h7f) begin
               s = s - 3'd1;
            end else begin
               s = 3'd0;
            end
         end
         ENC_SJIS: begin
            if (s < 3'd2 && c > 8'h80 && !(c > 8'h9f && c < 8'he0)) s = 3'd2;
            else if (s == 3'd2) s = 3'd1;
            else s = 3'd0;
         end
         ENC_BIG5, ENC_EUCCN: begin
            if (s < 3'd2 && c > 8'ha0) s = 3'd2;
            else if (s == 3'd2) s = 3'd1;
            else s = 3'd0;
         end
         ENC_GBK, ENC_UHC: begin
            if (s < 3'd2 && c > 8'h7f) s = 3'd2;
            else if (s == 3'd2) s = 3'd1;
            else s = 3'd0;
         end
         ENC_EUCJP: begin
            if (s < 3'd3 && c == 8'h8f) s = 3'd3;
            else if (s != 3'd2 && (c == 8'h8e || c > 8'ha0)) s = 3'd2;
            else if (s == 3'd2) s = 3'd1;
            else s = 3'd0;
         end
         ENC_EUCTW: begin
            if (s < 3'd4 && c == 8'h8e) s = 3'd4;
            else if (s == 3'd4 && c > 8'ha0) s = 3'd3;
            else if ((s == 3'd3 || s < 3'd2) && c > 8'ha0) s = 3'd2;
            else if (s == 3'd2) s = 3'd1;
            else s = 3'd0;
         end
         ENC_GB18030: begin
            if (s < 3'd2 && c > 8'h80) s = 3'd2;
            else if (s == 3'd2) s = digit ? 3'd3 : 3'd1;
            else if (s == 3'd3) s = digit ? 3'd1 : 3'd3;
            else s = 3'd0;
         end
         default: begin
            s = 3'd0;
         end
      endcase
      return s;
   endfunction

   // Predicts each accepted byte and checks each accepted word.
   always @(posedge clock) begin : track_words
      tracked_word_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         seq_now = advance_seq(seq_now, req_data_byte, mode_cfg);
         if (req_data_byte == 8'h00) begin
            chars_seen = '0;
         end else if (seq_now < 3'd2 && chars_seen != '1) begin
            chars_seen = chars_seen + 1'b1;
         end
         want.flags.state    = seq_now;
         want.flags.complete = (seq_now < 3'd2);
         want.flags.match    = (seq_now == 3'd0) && (req_data_byte == search_cfg);
         want.count          = chars_seen[OUT_COUNT_BITS-1:0];
         expected_words.push_back(want);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("word arrived with nothing expected");
         end else begin
            want = expected_words.pop_front();
            if (rsp_char_state !== want.flags.state)
               report_mismatch($sformatf("char_state %0d, expected %0d",
                                         rsp_char_state, want.flags.state));
            if (rsp_char_complete !== want.flags.complete)
               report_mismatch($sformatf("char_complete %0b, expected %0b",
                                         rsp_char_complete, want.flags.complete));
            if (rsp_byte_match !== want.flags.match)
               report_mismatch($sformatf("byte_match %0b, expected %0b",
                                         rsp_byte_match, want.flags.match));
            if (rsp_char_count !== want.count)
               report_mismatch($sformatf("char_count %0d, expected %0d",
                                         rsp_char_count, want.count));
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data_byte <= byte_backlog.pop_front();
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver serves long stall requests by counting cycles itself.
   always @(negedge clock) begin
      if (stall_requests != stalls_served) begin
         stalls_served++;
         stall_left = RSP_STALL_LEN;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_ENCODING_MODE) mode_cfg = value[3:0];
      else search_cfg = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_encoding(input logic [3:0] mode, input logic [7:0] search);
      // Upper bits of the data word are outside the encoding register.
      write_reg(REG_ENCODING_MODE, {4'($urandom_range(15)), mode});
      write_reg(REG_SEARCH_BYTE, search);
   endtask

   task automatic queue_bytes(input logic [7:0] list[]);
      foreach (list[k]) byte_backlog.push_back(list[k]);
   endtask

   function automatic logic [7:0] pick_byte(input int unsigned lo, input int unsigned hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   // Queues one character of the current encoding, now and then replaced by noise.
   task automatic queue_char();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(99);
      if (pick < 8) begin
         byte_backlog.push_back(pick_byte(0, 255));
         return;
      end
      if (pick < 35) begin
         byte_backlog.push_back(($urandom_range(3) == 0) ? search_cfg : pick_byte(1, 127));
         return;
      end
      case (mode_cfg)
         ENC_UTF8: begin
            len = $urandom_range(6, 2);
            case (len)
               2: byte_backlog.push_back(pick_byte(8'hc0, 8'hdf));
               3: byte_backlog.push_back(pick_byte(8'he0, 8'hef));
               4: byte_backlog.push_back(pick_byte(8'hf0, 8'hf7));
               5: byte_backlog.push_back(pick_byte(8'hf8, 8'hfb));
               default: byte_backlog.push_back(pick_byte(8'hfc, 8'hff));
            endcase
            repeat (len - 1) byte_backlog.push_back(pick_byte(8'h80, 8'hbf));
         end
         ENC_SJIS: begin
            byte_backlog.push_back($urandom_range(1) ? pick_byte(8'h81, 8'h9f)
                                                     : pick_byte(8'he0, 8'hff));
            byte_backlog.push_back(pick_byte(1, 255));
         end
         ENC_BIG5, ENC_EUCCN: begin
            byte_backlog.push_back(pick_byte(8'ha1, 8'hff));
            byte_backlog.push_back(pick_byte(1, 255));
         end
         ENC_GBK, ENC_UHC: begin
            byte_backlog.push_back(pick_byte(8'h80, 8'hff));
            byte_backlog.push_back(pick_byte(1, 255));
         end
         ENC_EUCJP: begin
            case ($urandom_range(2))
               0: byte_backlog.push_back(8'h8e);
               1: byte_backlog.push_back(pick_byte(8'ha1, 8'hff));
               default: begin
                  byte_backlog.push_back(8'h8f);
                  byte_backlog.push_back(pick_byte(8'ha1, 8'hff));
               end
            endcase
            byte_backlog.push_back(pick_byte(1, 255));
         end
         ENC_EUCTW: begin
            if ($urandom_range(1)) begin
               byte_backlog.push_back(8'h8e);
               byte_backlog.push_back(pick_byte(8'ha1, 8'hff));
            end
            byte_backlog.push_back(pick_byte(8'ha1, 8'hff));
            byte_backlog.push_back(pick_byte(1, 255));
         end
         ENC_GB18030: begin
            byte_backlog.push_back(pick_byte(8'h81, 8'hff));
            if ($urandom_range(1)) begin
               byte_backlog.push_back(pick_byte(8'h40, 8'hfe));
            end else begin
               // Four-byte form; non-digits between the digits hold the state.
               byte_backlog.push_back(pick_byte(8'h30, 8'h39));
               repeat ($urandom_range(2)) byte_backlog.push_back(pick_byte(8'h40, 8'hff));
               byte_backlog.push_back(pick_byte(8'h30, 8'h39));
            end
         end
         default: begin
            byte_backlog.push_back(pick_byte(1, 255));
         end
      endcase
   endtask

   task automatic wait_drained();
      while (byte_backlog.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [3:0] phase_modes[16];
      logic [7:0] search;
      int unsigned start_len;
      phase_modes = '{ENC_UTF8, ENC_SJIS, ENC_BIG5, ENC_GBK, ENC_UHC, ENC_EUCJP,
                      ENC_EUCCN, ENC_EUCTW, ENC_GB18030, ENC_SINGLE, ENC_SPARE_LO,
                      ENC_GB18030, ENC_UTF8, ENC_EUCJP, ENC_EUCTW, ENC_SPARE_HI};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: a few characters under single-byte, UTF-8, SJIS, EUC-JP, EUC-TW, GB18030 and a spare code.
      send_idle_pct = 25;
      rsp_idle_pct  = 59;
      set_encoding(ENC_SINGLE, 8'h00);
      queue_bytes('{8'h00, 8'hff, 8'h7f, 8'h01});
      wait_drained();
      set_encoding(ENC_UTF8, 8'h41);
      queue_bytes('{8'he2, 8'h82, 8'hac, 8'h80, 8'h41, 8'hfc, 8'h80, 8'h80, 8'h80, 8'h80,
                    8'h80, 8'he2, 8'h41});
      wait_drained();
      set_encoding(ENC_SJIS, 8'ha5);
      queue_bytes('{8'h81, 8'h40, 8'ha5});
      wait_drained();
      set_encoding(ENC_EUCJP, 8'h41);
      queue_bytes('{8'h8f, 8'ha1, 8'ha1, 8'h8e});
      wait_drained();
      // The change lands with a half-read EUC-JP character still open.
      set_encoding(ENC_EUCTW, 8'h41);
      queue_bytes('{8'h8e, 8'ha1, 8'ha2, 8'ha3, 8'h41});
      wait_drained();
      set_encoding(ENC_GB18030, 8'h41);
      queue_bytes('{8'h81, 8'h30, 8'h81, 8'h41, 8'h39, 8'h81, 8'h7e});
      wait_drained();
      set_encoding(ENC_SPARE_LO, 8'hc3);
      queue_bytes('{8'hc3, 8'h00, 8'hc3});
      wait_drained();

      // Random part: one encoding and search byte per phase.
      for (int p = 0; p < 16; p++) begin
         send_idle_pct = (p < 5) ? 25 : (p < 10) ? 59 : 0;
         rsp_idle_pct  = (p < 5) ? 59 : (p < 10) ? 25 : 0;
         case (p % 4)
            0: search = 8'hff;
            1: search = 8'h00;
            default: search = pick_byte(1, 127);
         endcase
         set_encoding(phase_modes[p], search);
         start_len = byte_backlog.size();
         while (byte_backlog.size() - start_len < PHASE_BYTES) queue_char();
         // Hold the receiver off while the sender keeps offering bytes.
         if (p == 10) stall_requests++;
         wait_drained();
      end

      // A short single-byte run, then a zero byte that clears the count.
      set_encoding(ENC_SINGLE, 8'h55);
      repeat (20) byte_backlog.push_back(pick_byte(1, 255));
      queue_bytes('{8'h55, 8'h00, 8'h55});
      wait_drained();

      if (fail_count == 0) begin
         $display("multibyte_char_boundary_tracker_unit_tb OK");
      end else begin
         $display("multibyte_char_boundary_tracker_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== multibyte_char_boundary_tracker_unit.f =====
rtl/mbct_pkg.sv
rtl/mbct_next.sv
rtl/multibyte_char_boundary_tracker_unit.sv
rtl/mbct_checker.sv
test/multibyte_char_boundary_tracker_unit_tb.sv
